/* hdl/amo_placement_predictor_table_defines.svh */
// assertion macros for the placement predictor table
`ifndef AMO_PLACEMENT_PREDICTOR_TABLE_DEFINES_SVH
`define AMO_PLACEMENT_PREDICTOR_TABLE_DEFINES_SVH

// clocked check, off while reset is asserted
`define APT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define APT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/apt_pkg.sv */
// types, constants and helper functions of the placement predictor table
package apt_pkg;

  localparam int ADDR_W   = 48;
  localparam int OFF_W    = 6;
  localparam int WAYS     = 4;
  localparam int WAY_W    = 2;
  localparam int SETS     = 64;
  localparam int SET_W    = 6;
  localparam int BLK_W    = ADDR_W - OFF_W;
  localparam int TAG_W    = BLK_W - SET_W;
  localparam int CONF_W   = 4;
  localparam int CNT_W    = 32;
  localparam int OCC_W    = 9;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    FN_PREDICT = 3'd0,
    FN_ALLOC   = 3'd1,
    FN_REUSE   = 3'd2,
    FN_UPDATE  = 3'd3,
    FN_EVICT   = 3'd4,
    FN_FETCH   = 3'd5
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEAR_THR = 2'd0,
    REG_CONF_CEIL = 2'd1
  } cfg_reg_e;

  typedef logic [WAYS-1:0][WAY_W-1:0] lru_t;

  typedef struct packed {
    logic [WAYS-1:0][TAG_W-1:0]  tag;
    logic [WAYS-1:0]             valid;
    logic [WAYS-1:0]             reuse;
    logic [WAYS-1:0][CONF_W-1:0] conf;
    lru_t                        lru;
  } row_t;

  typedef struct packed {
    logic rd;    // latch word and read its set
    logic exec;  // run the operation on the read set
  } cmd_t;

  function automatic lru_t lru_reset();
    lru_t r;
    for (int i = 0; i < WAYS; i++) begin
      r[i] = WAY_W'(i);
    end
    return r;
  endfunction

  // move way to most recent position
  function automatic lru_t lru_front(lru_t l, logic [WAY_W-1:0] way);
    lru_t r;
    logic [WAY_W:0] n;
    r = l;
    r[0] = way;
    n = (WAY_W+1)'(1);
    for (int i = 0; i < WAYS; i++) begin
      if (l[i] != way) begin
        r[n[WAY_W-1:0]] = l[i];
        n = n + 1'b1;
      end
    end
    return r;
  endfunction

  // move way to least recent position
  function automatic lru_t lru_back(lru_t l, logic [WAY_W-1:0] way);
    lru_t r;
    logic [WAY_W:0] n;
    r = l;
    n = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (l[i] != way) begin
        r[n[WAY_W-1:0]] = l[i];
        n = n + 1'b1;
      end
    end
    r[WAYS-1] = way;
    return r;
  endfunction

endpackage

/* hdl/apt_if.sv */
// handshake channels of the placement predictor table
interface apt_req_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                func;
  logic [apt_pkg::ADDR_W-1:0] addr;
  modport source (output valid, func, addr, input ready);
  modport sink (input valid, func, addr, output ready);
endinterface

interface apt_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic                      near;
  logic [apt_pkg::OCC_W-1:0] occupancy;
  modport source (output valid, hit, near, occupancy, input ready);
  modport sink (input valid, hit, near, occupancy, output ready);
endinterface

interface apt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [apt_pkg::CFG_IDX_W-1:0] index;
  logic [apt_pkg::CONF_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/amo_placement_predictor_table.sv */
// top level of the placement predictor table
// a word passes through read set, execute and respond before its result is shown
// one word at a time: the set read-modify-write of the single-port set memory is done,
// and the result is taken by the receiver, before the next word is taken
// reset: async active low; entry state reads as cleared through per-set written flags,
// so no clearing pass; thresholds return to 1 and 3, counters to zero
`include "amo_placement_predictor_table_defines.svh"
module amo_placement_predictor_table (
  input  logic     clk_i,
  input  logic     rst_ni,
  apt_req_if.sink  req_i,
  apt_rsp_if.source rsp_o,
  apt_cfg_if.sink  cfg_i
);
  import apt_pkg::*;

  cmd_t cmd;

  // config is always taken; writes must happen only while idle, which the block does not enforce
  assign cfg_i.ready = 1'b1;

  // sequencing of one word: accept, look up, respond
  apt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // set memory, replacement and global counters
  apt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .func_i      (req_i.func),
    .addr_i      (req_i.addr),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .hit_o       (rsp_o.hit),
    .near_o      (rsp_o.near),
    .occupancy_o (rsp_o.occupancy)
  );

  // one word in flight: never ready while a result is pending
  `APT_ASSERT(a_one_in_flight, rsp_o.valid |-> !req_i.ready, "ready while result pending")
  // an accepted word always gives a result once the lookup state has passed
  `APT_ASSERT(a_latency, (req_i.valid && req_i.ready) |=> ##1 rsp_o.valid, "result late")
  // occupancy never exceeds the table size
  `APT_ASSERT_ALWAYS(a_occ_max, rsp_o.occupancy <= 9'd256, "occupancy overflow")
endmodule

/* hdl/apt_ctrl.sv */
// controller state machine of the placement predictor table
module apt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output apt_pkg::cmd_t cmd_o
);
  import apt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_LOOK;
      ST_LOOK: state_d = ST_RESP;
      ST_RESP: if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_RESP);
  assign cmd_o.rd    = in_ready_o && in_valid_i;
  assign cmd_o.exec  = (state_q == ST_LOOK);
endmodule

/* hdl/apt_dp.sv */
// datapath: set memory, lookup, replacement, counters and result registers
module apt_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  apt_pkg::cmd_t                 cmd_i,
  input  logic [2:0]                    func_i,
  input  logic [apt_pkg::ADDR_W-1:0]    addr_i,
  input  logic                          cfg_we_i,
  input  logic [apt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [apt_pkg::CONF_W-1:0]    cfg_data_i,
  output logic                          hit_o,
  output logic                          near_o,
  output logic [apt_pkg::OCC_W-1:0]     occupancy_o
);
  import apt_pkg::*;

  row_t mem [SETS];
  logic [SETS-1:0] written_q;

  row_t             row_q;
  logic             rowv_q;
  logic [2:0]       func_q;
  logic [BLK_W-1:0] blk_q;

  logic [CONF_W-1:0] thr_q, ceil_q;
  logic [CNT_W-1:0]  brought_q, brought_d, reused_q, reused_d;
  logic [OCC_W-1:0]  occ_q, occ_d;
  logic              hit_q, near_q, near_d;

  logic [BLK_W-1:0] in_blk;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  row_t             cur, nrow;
  logic             hit;
  logic [WAY_W-1:0] way, vic;
  logic [CNT_W+CONF_W-1:0] prod_r, prod_b;
  logic [CONF_W-1:0] c;

  assign in_blk = addr_i[ADDR_W-1:OFF_W];
  assign set_q  = blk_q[SET_W-1:0];
  assign tag_q  = blk_q[BLK_W-1:SET_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      row_q  <= mem[in_blk[SET_W-1:0]];
      func_q <= func_i;
      blk_q  <= in_blk;
    end
    if (cmd_i.exec) begin
      mem[set_q] <= nrow;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rowv_q    <= 1'b0;
      thr_q     <= CONF_W'(1);
      ceil_q    <= CONF_W'(3);
      brought_q <= '0;
      reused_q  <= '0;
      occ_q     <= '0;
      hit_q     <= 1'b0;
      near_q    <= 1'b0;
    end else begin
      if (cmd_i.rd) rowv_q <= written_q[in_blk[SET_W-1:0]];
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_NEAR_THR) thr_q <= cfg_data_i;
        if (cfg_idx_i == REG_CONF_CEIL) ceil_q <= cfg_data_i;
      end
      if (cmd_i.exec) begin
        written_q[set_q] <= 1'b1;
        brought_q <= brought_d;
        reused_q  <= reused_d;
        occ_q     <= occ_d;
        hit_q     <= hit;
        near_q    <= near_d;
      end
    end
  end

  assign prod_r = (CNT_W+CONF_W)'(reused_q) * (CNT_W+CONF_W)'(ceil_q);
  assign prod_b = (CNT_W+CONF_W)'(brought_q) * (CNT_W+CONF_W)'(thr_q);

  always_comb begin
    cur = row_q;
    if (!rowv_q) begin
      cur.valid = '0;
      cur.reuse = '0;
      cur.conf  = '0;
      cur.lru   = lru_reset();
    end
    hit = 1'b0;
    way = '0;
    vic = cur.lru[WAYS-1];
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (cur.valid[w] && cur.tag[w] == tag_q) begin
        hit = 1'b1;
        way = WAY_W'(w);
      end
      if (!cur.valid[w]) vic = WAY_W'(w);
    end
    nrow      = cur;
    brought_d = brought_q;
    reused_d  = reused_q;
    occ_d     = occ_q;
    near_d    = 1'b0;
    c         = cur.conf[way];
    case (func_q)
      FN_PREDICT: begin
        if (hit) near_d = (c > thr_q);
        else if (brought_q == '0) near_d = 1'b1;
        else near_d = (prod_r >= prod_b);
      end
      FN_ALLOC: begin
        if (!hit) begin
          way = vic;
          if (!cur.valid[vic]) occ_d = occ_q + 1'b1;
        end
        nrow.tag[way]   = tag_q;
        nrow.valid[way] = 1'b1;
        nrow.reuse[way] = 1'b0;
        nrow.conf[way]  = ceil_q;
        nrow.lru        = lru_front(cur.lru, way);
        if (brought_q != '1) brought_d = brought_q + 1'b1;
      end
      FN_REUSE: begin
        if (hit) begin
          nrow.reuse[way] = 1'b1;
          nrow.lru        = lru_front(cur.lru, way);
        end
      end
      FN_UPDATE: begin
        if (hit) begin
          if (cur.reuse[way]) begin
            if (c < ceil_q) nrow.conf[way] = c + 1'b1;
            if (reused_q != '1) reused_d = reused_q + 1'b1;
          end else if (c != '0) begin
            nrow.conf[way] = c - 1'b1;
          end
          nrow.reuse[way] = 1'b0;
          nrow.lru        = lru_front(cur.lru, way);
        end
      end
      FN_EVICT: begin
        if (hit) begin
          nrow.valid[way] = 1'b0;
          nrow.reuse[way] = 1'b0;
          nrow.conf[way]  = '0;
          nrow.lru        = lru_back(cur.lru, way);
          occ_d           = occ_q - 1'b1;
        end
      end
      FN_FETCH: begin
        if (brought_q != '1) brought_d = brought_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign hit_o       = hit_q;
  assign near_o      = near_q;
  assign occupancy_o = occ_q;
endmodule

/* tb/sv/apt_tb_pkg.sv */
// testbench package: scoreboard class predicting the placement predictor table
`timescale 1ns / 1ps
package apt_tb_pkg;
  import apt_pkg::*;

  typedef struct packed {
    logic                 hit;
    logic                 near;
    logic [OCC_W-1:0]     occupancy;
  } outcome_t;

  class placement_scoreboard;
    logic [CONF_W-1:0] near_thr;
    logic [CONF_W-1:0] conf_ceil;
    logic [BLK_W-1:0]  blk_tag [SETS*WAYS];
    bit                line_valid [SETS*WAYS];
    bit                line_reuse [SETS*WAYS];
    logic [CONF_W-1:0] line_conf [SETS*WAYS];
    int unsigned       age_order [SETS][WAYS];
    logic [CNT_W-1:0]  fetched_lines;
    logic [CNT_W-1:0]  reused_lines;
    int unsigned       occupied;
    outcome_t          pending [$];
    int                errors;

    function new();
      near_thr = CONF_W'(1);
      conf_ceil = CONF_W'(3);
      fetched_lines = '0;
      reused_lines = '0;
      occupied = 0;
      errors = 0;
      for (int i = 0; i < SETS*WAYS; i++) begin
        line_valid[i] = 0;
        line_reuse[i] = 0;
        line_conf[i] = '0;
        blk_tag[i] = '0;
      end
      for (int s = 0; s < SETS; s++)
        for (int w = 0; w < WAYS; w++) age_order[s][w] = w;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CONF_W-1:0] val);
      if (idx == REG_NEAR_THR) near_thr = val;
      else if (idx == REG_CONF_CEIL) conf_ceil = val;
    endfunction

    function void move_way(int unsigned s, int unsigned way, int unsigned pos);
      int unsigned rest [$];
      int n;
      rest = {};
      for (int i = 0; i < WAYS; i++)
        if (age_order[s][i] != way) rest = {rest, age_order[s][i]};
      n = 0;
      for (int i = 0; i < WAYS; i++) begin
        if (i == pos) age_order[s][i] = way;
        else begin
          age_order[s][i] = rest[n];
          n++;
        end
      end
    endfunction

    function logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
      return (&v) ? v : v + 1;
    endfunction

    // note an accepted word and predict its result
    function void note_word(logic [2:0] fn, logic [ADDR_W-1:0] addr);
      logic [BLK_W-1:0] blk;
      int unsigned s, base, v;
      int way;
      bit near;
      outcome_t o;
      blk = addr[ADDR_W-1:OFF_W];
      s = {26'd0, blk[SET_W-1:0]};
      base = s * WAYS;
      way = -1;
      near = 0;
      for (int w = 0; w < WAYS; w++)
        if (way < 0 && line_valid[base+w] && blk_tag[base+w] == blk) way = w;
      case (fn)
        FN_PREDICT: begin
          if (way >= 0) near = line_conf[base+way] > near_thr;
          else if (fetched_lines == 0) near = 1;
          else near = ({4'd0, reused_lines} * conf_ceil) >=
                      ({4'd0, fetched_lines} * near_thr);
        end
        FN_ALLOC: begin
          if (way >= 0) v = way;
          else begin
            v = age_order[s][WAYS-1];
            for (int w = WAYS-1; w >= 0; w--) if (!line_valid[base+w]) v = w;
            if (!line_valid[base+v]) occupied++;
          end
          blk_tag[base+v] = blk;
          line_valid[base+v] = 1;
          line_reuse[base+v] = 0;
          line_conf[base+v] = conf_ceil;
          move_way(s, v, 0);
          fetched_lines = sat_inc(fetched_lines);
        end
        FN_REUSE: if (way >= 0) begin
          line_reuse[base+way] = 1;
          move_way(s, way, 0);
        end
        FN_UPDATE: if (way >= 0) begin
          if (line_reuse[base+way]) begin
            if (line_conf[base+way] < conf_ceil) line_conf[base+way]++;
            reused_lines = sat_inc(reused_lines);
          end else if (line_conf[base+way] > 0) line_conf[base+way]--;
          line_reuse[base+way] = 0;
          move_way(s, way, 0);
        end
        FN_EVICT: if (way >= 0) begin
          line_valid[base+way] = 0;
          line_reuse[base+way] = 0;
          line_conf[base+way] = '0;
          occupied--;
          move_way(s, way, WAYS-1);
        end
        FN_FETCH: fetched_lines = sat_inc(fetched_lines);
        default: ;
      endcase
      o.hit = way >= 0;
      o.near = near;
      o.occupancy = occupied[OCC_W-1:0];
      pending = {pending, o};
    endfunction

    function void report(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
    endfunction

    // compare a result word with the oldest prediction
    function void check_result(logic hit, logic near, logic [OCC_W-1:0] occ);
      outcome_t e;
      if (pending.size() == 0) begin
        report("unexpected result", '0, '0);
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit) report("hit", 16'(hit), 16'(e.hit));
      if (near !== e.near) report("near", 16'(near), 16'(e.near));
      if (occ !== e.occupancy) report("occupancy", 16'(occ), 16'(e.occupancy));
    endfunction
  endclass
endpackage

/* tb/sv/testbench.sv */
// top level testbench of the placement predictor table
`timescale 1ns / 1ps
module testbench;
  import apt_pkg::*;
  import apt_tb_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;

  apt_req_if req ();
  apt_rsp_if rsp ();
  apt_cfg_if cfg ();

  amo_placement_predictor_table i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp),
    .cfg_i (cfg)
  );

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  placement_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  bit rsp_hold = 0;       // long receiver hold-off
  bit rsp_idle_on = 1;    // random receiver stalls
  logic [ADDR_W-1:0] hot_addr [16];   // small pool to force hits and conflicts

  initial begin
    req.valid = 0;
    req.func = '0;
    req.addr = '0;
    rsp.ready = 0;
    cfg.valid = 0;
    cfg.index = '0;
    cfg.data = '0;
  end

  // random gap length: mostly short, sometimes long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver side: random stalls, checks on accepted words
  initial begin
    int unsigned g;
    @(posedge rst_ni);
    forever begin
      g = rsp_idle_on ? gap_len() : 0;
      if (rsp_hold || g > 0) begin
        rsp.ready <= 0;
        repeat (g > 0 ? g : 1) @(posedge clk_i);
      end else begin
        rsp.ready <= 1;
        @(posedge clk_i);
        if (rsp.valid && rsp.ready) sb.check_result(rsp.hit, rsp.near, rsp.occupancy);
      end
    end
  end

  // watchdog: cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_word(logic [2:0] fn, logic [ADDR_W-1:0] addr, bit gaps);
    int unsigned g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      req.valid <= 0;
      repeat (g) @(posedge clk_i);
    end
    req.valid <= 1;
    req.func <= fn;
    req.addr <= addr;
    do @(posedge clk_i); while (!req.ready);
    sb.note_word(fn, addr);
  endtask

  task automatic end_burst();
    req.valid <= 0;
  endtask

  // wait until all results are back, then let the pipeline settle
  task automatic drain();
    end_burst();
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CONF_W-1:0] val);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk_i); while (!cfg.ready);
    sb.set_reg(idx, val);
    cfg.valid <= 0;
    @(posedge clk_i);
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  // weighted operation mix; codes 6 and 7 appear as noise
  function automatic logic [2:0] rand_func();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 22) return FN_PREDICT;
    if (r < 44) return FN_ALLOC;
    if (r < 60) return FN_REUSE;
    if (r < 78) return FN_UPDATE;
    if (r < 88) return FN_EVICT;
    if (r < 95) return FN_FETCH;
    return 3'($urandom_range(6, 7));
  endfunction

  task automatic random_phase(int n);
    logic [ADDR_W-1:0] a;
    for (int i = 0; i < n; i++) begin
      // mostly a small pool of lines, some sharing sets, plus fully random ones
      if ($urandom_range(0, 9) < 8) a = hot_addr[$urandom_range(0, 15)];
      else a = rand_addr();
      send_word(rand_func(), a, 1);
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] e;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // pool: eight lines in set 5 (conflicts beyond four ways), rest scattered
    for (int i = 0; i < 16; i++) begin
      if (i < 8) hot_addr[i] = rand_addr() & ~48'hfff | (48'd5 << OFF_W)
                               | 48'($urandom_range(0, 63));
      else hot_addr[i] = rand_addr();
    end
    hot_addr[8] = '0;
    hot_addr[9] = '1;

    // directed: empty predict, unused codes, one line walked through all ops, then set 5 overfilled
    e = 48'h0000_1234_5678;
    send_word(FN_PREDICT, e, 0);
    send_word(3'd6, e, 0);
    send_word(3'd7, '1, 0);
    send_word(FN_EVICT, e, 0);
    send_word(FN_ALLOC, e, 0);
    send_word(FN_PREDICT, e, 0);
    send_word(FN_REUSE, e, 0);
    send_word(FN_UPDATE, e, 0);
    send_word(FN_UPDATE, e, 0);
    send_word(FN_FETCH, '1, 0);
    send_word(FN_PREDICT, '0, 0);
    send_word(FN_ALLOC, e, 0);
    for (int i = 0; i < 6; i++) send_word(FN_ALLOC, hot_addr[i], 0);
    send_word(FN_EVICT, hot_addr[5], 0);
    send_word(FN_ALLOC, '1, 0);
    send_word(FN_ALLOC, '0, 0);
    send_word(FN_PREDICT, '1, 0);
    drain();

    // phases over register settings, extremes included
    write_reg(REG_NEAR_THR, 4'd0);
    write_reg(REG_CONF_CEIL, 4'd15);
    random_phase(400);

    // receiver holds off while sender keeps offering words
    rsp_hold = 1;
    fork
      random_phase(60);
      begin
        repeat (200) @(posedge clk_i);
        rsp_hold = 0;
      end
    join
    drain();

    write_reg(REG_NEAR_THR, 4'd15);
    write_reg(REG_CONF_CEIL, 4'd1);
    random_phase(400);
    drain();

    // random threshold and ceiling, with random receiver stalls off
    write_reg(REG_NEAR_THR, CONF_W'($urandom_range(0, 15)));
    write_reg(REG_CONF_CEIL, CONF_W'($urandom_range(1, 15)));
    rsp_idle_on = 0;
    random_phase(300);
    rsp_idle_on = 1;
    drain();

    write_reg(REG_NEAR_THR, 4'd10);
    write_reg(REG_CONF_CEIL, 4'd5);
    random_phase(400);
    drain();

    write_reg(REG_NEAR_THR, 4'd1);
    write_reg(REG_CONF_CEIL, 4'd3);
    random_phase(270);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

/* amo_placement_predictor_table.f */
+incdir+hdl
hdl/apt_pkg.sv
hdl/apt_if.sv
hdl/apt_ctrl.sv
hdl/apt_dp.sv
hdl/amo_placement_predictor_table.sv
tb/sv/apt_tb_pkg.sv
tb/sv/testbench.sv
